// File: hw/rtl/sbf_pkg.sv
// ============================================================================
// sbf_pkg - shared types and constants for the sharpen and blend filter
// Register map, input kind codes and fixed field widths.
// ============================================================================
package sbf_pkg;

    localparam int SAMPLE_W       = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int LINE_WIDTH_W   = 12;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int COMPONENTS_W   = 3;
    localparam int OPACITY_W      = 7;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COMPONENTS   = 2'd2,
        CFG_OPACITY      = 2'd3
    } t_cfg_index;

    // Input transaction kind
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    // Register values after reset
    localparam logic [LINE_WIDTH_W-1:0]   RST_LINE_WIDTH   = 12'd2;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 16'd2;
    localparam logic [COMPONENTS_W-1:0]   RST_COMPONENTS   = 3'd3;
    localparam logic [OPACITY_W-1:0]      RST_OPACITY      = 7'd0;

endpackage

// File: hw/rtl/sharpen_and_blend_filter_top.sv
// ============================================================================
// sharpen_and_blend_filter_top - cross Laplacian sharpen with opacity blend
// Streams interleaved component bytes, sharpens interior samples against their
// four cross neighbours, blends with the original and lags input by one row.
// ============================================================================
// Throughput: one transaction per cycle on both channels unless the output
//   stalls, set by the two line stores (middle: one write and two registered
//   reads per cycle; upper: one write, one read). A result passes the store
//   read register, blend register and output register; results trail by a row.
// Reset: counters, pipeline valids and left taps clear, registers take their
//   defaults; the line stores are not cleared and need no clearing pass.
module sharpen_and_blend_filter_top #(
    parameter int MAX_LINE_PIXELS = 2048,
    parameter int MAX_COMPONENTS  = 4,
    parameter int OPACITY_SCALE   = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  sbf_pkg::t_cfg_index               i_cfg_index,
    input  logic [sbf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sbf_pkg::t_kind                    i_kind,
    input  logic [sbf_pkg::SAMPLE_W-1:0]      i_sample,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sbf_pkg::SAMPLE_W-1:0]      o_out_sample,
    output logic                              o_frame_last
);
    import sbf_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int STORE_DEPTH = MAX_LINE_PIXELS * MAX_COMPONENTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_LINE_PIXELS);
    localparam int W_W         = $clog2(MAX_LINE_PIXELS + 1);
    localparam int COMP_W      = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int C_W         = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS + 1) : 1;
    localparam int DR_W        = $clog2(STORE_DEPTH + 1);
    localparam int OP_W        = (OPACITY_SCALE > 1) ? $clog2(OPACITY_SCALE + 1) : 1;
    localparam int SUM_W       = $clog2(OPACITY_SCALE * 255 + 1);
    // Exact division by the opacity scale: multiply by a rounded-up
    // reciprocal; the extra shift bits make the quotient exact over SUM_W.
    localparam int DIV_SHIFT   = SUM_W + $clog2(OPACITY_SCALE);
    localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + OPACITY_SCALE - 1) / OPACITY_SCALE;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(DIV_RECIP);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LINE_WIDTH_W-1:0]   r_line_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [COMPONENTS_W-1:0]   r_components;
    logic [OPACITY_W-1:0]      r_opacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_components   <= RST_COMPONENTS;
            r_opacity      <= RST_OPACITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LINE_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                CFG_COMPONENTS:   r_components   <= i_cfg_data[COMPONENTS_W-1:0];
                CFG_OPACITY:      r_opacity      <= i_cfg_data[OPACITY_W-1:0];
                default: ;
            endcase
        end
    end

    // Working values: clamp each register into the range the datapath covers
    logic [W_W-1:0]            eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;
    logic [C_W-1:0]            eff_c;
    logic [OP_W-1:0]           eff_op;

    always_comb begin
        if (32'(r_line_width) < 2) begin
            eff_w = W_W'(2);
        end else if (32'(r_line_width) > MAX_LINE_PIXELS) begin
            eff_w = W_W'(MAX_LINE_PIXELS);
        end else begin
            eff_w = W_W'(r_line_width);
        end

        eff_h = (r_frame_height < FRAME_HEIGHT_W'(2)) ? FRAME_HEIGHT_W'(2) : r_frame_height;

        if (r_components == '0) begin
            eff_c = C_W'(1);
        end else if (32'(r_components) > MAX_COMPONENTS) begin
            eff_c = C_W'(MAX_COMPONENTS);
        end else begin
            eff_c = C_W'(r_components);
        end

        if (32'(r_opacity) > OPACITY_SCALE) begin
            eff_op = OP_W'(OPACITY_SCALE);
        end else begin
            eff_op = OP_W'(r_opacity);
        end
    end

    // ------------------------------------------------------------------
    // Raster position and drain counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0]          r_col,  n_col;
    logic [FRAME_HEIGHT_W-1:0] r_row,  n_row;
    logic [COMP_W-1:0]         r_comp, n_comp;
    logic [DR_W-1:0]           r_drain_rem, n_drain_rem;

    logic                      accept;
    logic                      drain_pend;
    logic                      do_drain;
    logic                      img_write;
    logic                      produced;
    logic                      interior;
    logic [C_W-1:0]            comp_nxt;
    logic                      comp_wrap;
    logic [W_W-1:0]            col_nxt;
    logic                      col_wrap;
    logic [FRAME_HEIGHT_W:0]   row_nxt;
    logic                      row_wrap;
    logic [DR_W-1:0]           drain_nxt;
    logic [ADDR_W:0]           p_ext;
    logic [ADDR_W:0]           pr_ext;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         right_addr;

    assign accept     = i_in_valid && o_in_ready;
    assign drain_pend = (r_drain_rem != '0);
    // A drain tick with nothing owed and a sample during a drain both drop
    assign do_drain   = accept && (i_kind == KIND_DRAIN) && drain_pend;
    assign img_write  = accept && (i_kind == KIND_SAMPLE) && !drain_pend;
    // Samples of the first row only fill the stores
    assign produced   = img_write && (r_row != '0);

    assign comp_nxt   = C_W'(r_comp) + C_W'(1);
    assign comp_wrap  = (comp_nxt >= eff_c);
    assign col_nxt    = W_W'(r_col) + W_W'(1);
    assign col_wrap   = (col_nxt >= eff_w);
    assign row_nxt    = {1'b0, r_row} + (FRAME_HEIGHT_W + 1)'(1);
    assign row_wrap   = (row_nxt >= {1'b0, eff_h});
    assign drain_nxt  = r_drain_rem - DR_W'(1);

    // Output row is one above the input row; anything on the frame edge,
    // or outside the current limits, passes through unfiltered
    assign interior = (r_row >= FRAME_HEIGHT_W'(2)) && (r_row < eff_h)
                   && (r_col != '0) && (W_W'(r_col) < (eff_w - W_W'(1)));

    // Store address of this sample and of the same component one pixel right
    always_comb begin
        p_ext = (ADDR_W + 1)'(r_col) * (ADDR_W + 1)'(eff_c) + (ADDR_W + 1)'(r_comp);
        pr_ext = p_ext + (ADDR_W + 1)'(eff_c);
        if (pr_ext >= (ADDR_W + 1)'(STORE_DEPTH)) begin
            pr_ext = pr_ext - (ADDR_W + 1)'(STORE_DEPTH);
        end
        rd_addr    = p_ext[ADDR_W-1:0];
        right_addr = pr_ext[ADDR_W-1:0];
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_comp      = r_comp;
        n_drain_rem = r_drain_rem;
        if (img_write) begin
            if (comp_wrap) begin
                n_comp = '0;
                if (col_wrap) begin
                    n_col = '0;
                    if (row_wrap) begin
                        n_row       = '0;
                        n_drain_rem = DR_W'(eff_w) * DR_W'(eff_c);
                    end else begin
                        n_row = row_nxt[FRAME_HEIGHT_W-1:0];
                    end
                end else begin
                    n_col = COL_W'(col_nxt);
                end
            end else begin
                n_comp = COMP_W'(comp_nxt);
            end
        end else if (do_drain) begin
            n_drain_rem = drain_nxt;
            if (drain_nxt == '0) begin
                // frame fully flushed: restart at the top left
                n_col  = '0;
                n_comp = '0;
            end else if (comp_wrap) begin
                n_comp = '0;
                n_col  = col_wrap ? '0 : COL_W'(col_nxt);
            end else begin
                n_comp = COMP_W'(comp_nxt);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic r_s1_res;
    logic r_s1_wr;
    logic out_free;
    logic s2_free;
    logic s1_adv;
    logic s1_commit;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_free    = !r_s2_valid || out_free;
    // A transaction with no result leaves stage 1 without waiting on the output
    assign s1_adv     = r_s1_valid && (!r_s1_res || s2_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign s1_commit  = s1_adv && r_s1_wr;

    // ------------------------------------------------------------------
    // Line stores: middle holds row r-1, upper holds row r-2
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_mid_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_up_mem  [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_centre;
    logic [SAMPLE_W-1:0] r_right;
    logic [SAMPLE_W-1:0] r_up;
    logic [ADDR_W-1:0]   r_s1_addr;

    // Middle row: write the incoming sample where its centre is read
    // (read returns the old contents, i.e. row r-1)
    always_ff @(posedge i_clk) begin
        if (img_write) begin
            r_mid_mem[rd_addr] <= i_sample;
        end
        if (accept) begin
            r_centre <= r_mid_mem[rd_addr];
            r_right  <= r_mid_mem[right_addr];
        end
    end

    // Upper row: the displaced centre moves down one row when stage 1 retires
    always_ff @(posedge i_clk) begin
        if (s1_commit) begin
            r_up_mem[r_s1_addr] <= r_centre;
        end
        if (accept) begin
            r_up <= r_up_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sharpen and blend products
    // ------------------------------------------------------------------
    logic                r_s1_interior;
    logic                r_s1_last;
    logic [SAMPLE_W-1:0] r_s1_down;
    logic [COMP_W-1:0]   r_s1_k;
    logic [SAMPLE_W-1:0] r_taps [MAX_COMPONENTS];

    logic [SAMPLE_W-1:0] left;
    logic signed [11:0]  lap;
    logic [SAMPLE_W-1:0] sharp;
    logic [OP_W-1:0]     op_used;
    logic [SUM_W-1:0]    blend_sum;

    always_comb begin
        left = r_taps[r_s1_k];
        lap  = 12'sd5 * $signed({4'b0, r_centre})
             - $signed({4'b0, r_up})
             - $signed({4'b0, r_s1_down})
             - $signed({4'b0, left})
             - $signed({4'b0, r_right});
        if (lap < 12'sd0) begin
            sharp = '0;
        end else if (lap > 12'sd255) begin
            sharp = 8'd255;
        end else begin
            sharp = lap[SAMPLE_W-1:0];
        end
        // Zero weight on the edges turns the blend into a plain pass-through
        op_used   = r_s1_interior ? eff_op : '0;
        blend_sum = SUM_W'(op_used) * SUM_W'(sharp)
                  + SUM_W'(OP_W'(OPACITY_SCALE) - op_used) * SUM_W'(r_centre);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res      <= produced || do_drain;
            r_s1_wr       <= img_write;
            r_s1_interior <= img_write && interior;
            r_s1_last     <= do_drain && (drain_nxt == '0);
            r_s1_down     <= i_sample;
            r_s1_k        <= r_comp;
            r_s1_addr     <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by the opacity scale
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    r_s2_sum;
    logic                r_s2_last;
    logic [PROD_W-1:0]   quot_prod;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;

    assign quot_prod = PROD_W'(r_s2_sum) * PROD_W'(RECIP_VAL);

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_res) begin
            r_s2_sum  <= blend_sum;
            r_s2_last <= r_s1_last;
        end
        if (r_s2_valid && out_free) begin
            r_out_sample <= quot_prod[DIV_SHIFT +: SAMPLE_W];
            r_out_last   <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_comp      <= '0;
            r_drain_rem <= '0;
            for (int i = 0; i < MAX_COMPONENTS; i++) begin
                r_taps[i] <= '0;
            end
        end else begin
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
            if (s2_free) begin
                r_s2_valid <= s1_adv && r_s1_res;
            end
            if (o_in_ready) begin
                r_s1_valid <= img_write || do_drain;
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_comp      <= n_comp;
            r_drain_rem <= n_drain_rem;
            // Hold the row r-1 value as next pixel's left neighbour
            if (s1_commit) begin
                r_taps[r_s1_k] <= r_centre;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_frame_last = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input must stall once every stage is full behind a blocked output
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_res && r_s2_valid && r_out_valid && !i_out_ready)
        |-> !o_in_ready)
        else $error("input accepted with a full, stalled pipeline");

    // The last sample of a frame must arm the drain
    a_drain_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (img_write && comp_wrap && col_wrap && row_wrap) |=> (r_drain_rem != '0))
        else $error("frame end did not arm the drain");

    // The final drain transaction returns the position to the top left
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_drain && (drain_nxt == '0))
        |=> (r_col == '0 && r_comp == '0 && r_drain_rem == '0 && r_row == '0))
        else $error("drain end left a stale position");

endmodule
